// ===== src/lth_pkg.sv =====
// ============================================================================
// lth_pkg
// Shared types and constants for the LRU TLB hit counter.
// ============================================================================
`default_nettype none

package lth_pkg;

    // Default sizing, handed to the top-level parameters
    localparam int TLB_ENTRIES_DEF = 16;
    localparam int ADDR_BITS_DEF   = 32;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CFG_REG_W  = 5;

    // Register index, taken from the word address bit
    localparam logic REG_IDX_PAGE_OFFSET = 1'b0;
    localparam logic REG_IDX_ENTRIES     = 1'b1;

    // Register reset values
    localparam logic [CFG_REG_W-1:0] PAGE_OFFSET_RST = 5'd12;
    localparam logic [CFG_REG_W-1:0] ENTRIES_RST     = 5'd16;

    // Hit total width
    localparam int HIT_W = 32;

    // Control from the pipeline to the tag store
    typedef struct packed {
        logic update;   // a lookup retires this cycle
        logic flush;    // clear the table after this lookup
    } t_tag_ctl;

endpackage

`default_nettype wire

// ===== src/lth_cfg_regs.sv =====
// ============================================================================
// lth_cfg_regs
// APB register file: page offset shift and entry limit, with limit clamping.
// ============================================================================
`default_nettype none

module lth_cfg_regs
    import lth_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    localparam int CW = $clog2(TLB_ENTRIES + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [CFG_REG_W-1:0]  o_page_shift,
    output logic      [CW-1:0]         o_limit
);

    logic [CFG_REG_W-1:0] r_page_shift;
    logic [CFG_REG_W-1:0] r_entries;
    logic                 wr_en;
    logic                 reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_shift <= PAGE_OFFSET_RST;
            r_entries    <= ENTRIES_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_IDX_PAGE_OFFSET: r_page_shift <= pwdata[CFG_REG_W-1:0];
                REG_IDX_ENTRIES:     r_entries    <= pwdata[CFG_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_IDX_PAGE_OFFSET: prdata = APB_DATA_W'(r_page_shift);
            REG_IDX_ENTRIES:     prdata = APB_DATA_W'(r_entries);
            default:             prdata = '0;
        endcase
    end

    // Zero acts as one; saturate at the table size
    always_comb begin
        if (r_entries == '0) begin
            o_limit = CW'(1);
        end else if (int'(r_entries) > TLB_ENTRIES) begin
            o_limit = CW'(TLB_ENTRIES);
        end else begin
            o_limit = CW'(r_entries);
        end
    end

    assign o_page_shift = r_page_shift;

endmodule

`default_nettype wire

// ===== src/lth_tag_store.sv =====
// ============================================================================
// lth_tag_store
// Fully associative tag array with LRU ranks, parallel compare and update.
// ============================================================================
`default_nettype none

module lth_tag_store
    import lth_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    localparam int CW = $clog2(TLB_ENTRIES + 1),
    localparam int RW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_tag_ctl             i_ctl,
    input  wire logic [ADDR_BITS-1:0] i_page,
    input  wire logic [CW-1:0]        i_limit,
    output logic                      o_hit
);

    logic [ADDR_BITS-1:0]   r_page [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_valid;
    logic [RW-1:0]          r_rank [TLB_ENTRIES];
    logic [CW-1:0]          r_count;

    logic [TLB_ENTRIES-1:0] n_valid;
    logic [RW-1:0]          n_rank [TLB_ENTRIES];
    logic [CW-1:0]          n_count;

    logic [TLB_ENTRIES-1:0] hit_vec;
    logic [TLB_ENTRIES-1:0] free_vec;
    logic [TLB_ENTRIES-1:0] victim_vec;
    logic [TLB_ENTRIES-1:0] wr_vec;
    logic [RW-1:0]          hit_rank;
    logic                   free_found;
    logic                   do_fill;
    logic [CW-1:0]          age_thr;

    // Compare, free-slot search and victim match
    always_comb begin
        hit_rank   = '0;
        free_vec   = '0;
        free_found = 1'b0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            hit_vec[i]    = r_valid[i] && (r_page[i] == i_page);
            victim_vec[i] = r_valid[i] && (CW'(r_rank[i]) == (r_count - CW'(1)));
            if (hit_vec[i]) begin
                hit_rank = hit_rank | r_rank[i];
            end
            if (!r_valid[i] && !free_found) begin
                free_vec[i] = 1'b1;
                free_found  = 1'b1;
            end
        end
    end

    assign o_hit   = |hit_vec;
    assign do_fill = !o_hit && (r_count < i_limit);

    // Entries more recent than the threshold age by one
    always_comb begin
        if (o_hit) begin
            age_thr = CW'(hit_rank);
            wr_vec  = hit_vec;
        end else if (do_fill) begin
            age_thr = r_count;
            wr_vec  = free_vec;
        end else begin
            age_thr = r_count - CW'(1);
            wr_vec  = victim_vec;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (r_valid[i] && (CW'(r_rank[i]) < age_thr)) begin
                n_rank[i] = r_rank[i] + RW'(1);
            end
            if (wr_vec[i]) begin
                n_rank[i] = '0;
            end
        end
        if (do_fill) begin
            n_valid = r_valid | free_vec;
            n_count = r_count + CW'(1);
        end
        if (i_ctl.flush) begin
            n_valid = '0;
            n_count = '0;
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                n_rank[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_ctl.update) begin
            r_valid <= n_valid;
            r_count <= n_count;
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    // Tags carry no reset; only read behind a valid bit
    always_ff @(posedge i_clk) begin
        if (i_ctl.update && !o_hit) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                if (wr_vec[i]) begin
                    r_page[i] <= i_page;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_valid)))
        else $error("valid count out of step with valid bits");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.update && i_ctl.flush) |=> (r_count == '0) && (r_valid == '0))
        else $error("table not cleared after trace end");

    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.update && !i_ctl.flush && do_fill) |=> r_count == $past(r_count) + CW'(1))
        else $error("fill did not add an entry");

    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit_vec))
        else $error("page found in more than one entry");
`endif

endmodule

`default_nettype wire

// ===== src/lru_tlb_hit_counter_core.sv =====
// ============================================================================
// lru_tlb_hit_counter_core
// LRU fully associative TLB tag store that reports hits and a running total.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one access per transfer:
//   a virtual address and a trace-end mark. Output channel (o_out_valid /
//   i_out_stall) returns one result per access: hit flag and hit total of
//   the trace including this access.
//   The page number is formed as the access enters the input register; the
//   tag compare, LRU rank update and hit count happen between the input
//   register and the result register, and each access passes the input
//   register and then the result register. One access per cycle is
//   sustained while the receiver does not stall, set by the combinational
//   compare and rank update of the tag store.
//   When the receiver stalls, the result register holds and the input
//   register keeps its access; o_in_stall rises only while both are full.
//   On an access marked trace end the table and the total clear right after
//   its result is formed.
//   Reset clears the table, the total and both channel stages, and restores
//   page offset 12 and entry limit 16. The user must configure via the APB
//   port (offset 0x0, limit 0x4) only while the block is idle; not enforced.
// ============================================================================
`default_nettype none

module lru_tlb_hit_counter_core
    import lth_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Access channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [ADDR_BITS-1:0]  i_virtual_address,
    input  wire logic                  i_final_access,
    // Result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_was_hit,
    output logic      [HIT_W-1:0]      o_hits_so_far,
    // Configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int CW = $clog2(TLB_ENTRIES + 1);

    logic [CFG_REG_W-1:0] page_shift;
    logic [CW-1:0]        limit;

    // Input stage
    logic                 r_in_valid;
    logic [ADDR_BITS-1:0] r_in_page;
    logic                 r_in_final;

    // Result stage
    logic                 r_out_valid;
    logic                 r_was_hit;
    logic [HIT_W-1:0]     r_hits;
    logic [HIT_W-1:0]     r_total;
    logic [HIT_W-1:0]     n_total;

    logic                 in_xfer;
    logic                 load_ok;
    logic                 advance;
    logic                 hit;
    t_tag_ctl             tag_ctl;

    lth_cfg_regs #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_page_shift (page_shift),
        .o_limit      (limit)
    );

    // Result register takes a new value when empty or being drained
    assign load_ok    = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && load_ok;
    assign o_in_stall = r_in_valid && !load_ok;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Form the page number on entry; the user must keep the shift stable while traffic flows, not enforced here
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_page  <= i_virtual_address >> page_shift;
            r_in_final <= i_final_access;
        end
    end

    assign tag_ctl.update = advance;
    assign tag_ctl.flush  = r_in_final;

    lth_tag_store #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_tags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tag_ctl),
        .i_page  (r_in_page),
        .i_limit (limit),
        .o_hit   (hit)
    );

    assign n_total = r_total + HIT_W'(hit);

    // Total counts within a trace; drop it after the trace end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_total     <= r_in_final ? '0 : n_total;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_was_hit <= hit;
            r_hits    <= n_total;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_was_hit     = r_was_hit;
    assign o_hits_so_far = r_hits;

`ifndef SYNTHESIS
    a_advance_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("retired access produced no result");

    a_miss_holds_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !hit && !r_in_final) |=> r_total == $past(r_total))
        else $error("hit total moved on a miss");

    a_trace_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_final) |=> r_total == '0)
        else $error("hit total not cleared after trace end");
`endif

endmodule

`default_nettype wire
